// ===== src/lpg_pkg.sv =====
// Package for the line pixel generator: word types of both channels, mode and
// direction codes, and default sizes. No dependencies.
`default_nettype none

package lpg_pkg;

  // Width of every coordinate field on the ports.
  localparam int FIELD_BITS = 11;

  // Default width of the internal coordinate arithmetic.
  localparam int COORD_BITS_DEF = 11;

  // Number of entries in the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Mode codes of an input word.
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  // Step direction of one axis.
  localparam logic [1:0] DIR_NONE  = 2'd0;
  localparam logic [1:0] DIR_PLUS  = 2'd1;
  localparam logic [1:0] DIR_MINUS = 2'd3;

  typedef struct packed {
    logic                  mode;
    logic [FIELD_BITS-1:0] start_x;
    logic [FIELD_BITS-1:0] start_y;
    logic [FIELD_BITS-1:0] end_x;
    logic [FIELD_BITS-1:0] end_y;
  } in_word_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] pixel_x;
    logic [FIELD_BITS-1:0] pixel_y;
    logic                  last;
  } out_word_t;

  // Bits of one queued command: load flag, start column and row, both spans,
  // the major span and both directions.
  function automatic int cmd_bits(input int cw);
    return 5 * cw + 5;
  endfunction

endpackage

`default_nettype wire

// ===== src/lpg_queue.sv =====
// Small first-word-fall-through queue between the front and the back.
// Depends on nothing; width and depth come from the instantiating module.
`default_nettype none

module lpg_queue #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  output logic                  nonempty,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);
  assign pop_data = slots[rd_ptr];

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== src/lpg_front.sv =====
// Front of the line pixel generator: takes input words, works out spans,
// directions and the major span of a load, and pushes commands to the queue.
// Depends on lpg_pkg.
`default_nettype none

module lpg_front #(
  parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    cmd_valid,
  output logic                                         cmd_stall,
  input  wire lpg_pkg::in_word_t                       cmd,
  output logic                                         q_push,
  input  wire logic                                    q_full,
  output logic [lpg_pkg::cmd_bits(COORD_BITS)-1:0]     q_data
);

  import lpg_pkg::*;

  localparam int CW = COORD_BITS;

  typedef struct packed {
    logic          load;
    logic [CW-1:0] col;
    logic [CW-1:0] row;
    logic [CW-1:0] span_col;
    logic [CW-1:0] span_row;
    logic [CW-1:0] major;
    logic [1:0]    dir_col;
    logic [1:0]    dir_row;
  } cmd_t;

  cmd_t          held;
  cmd_t          held_next;
  logic          held_valid;
  logic [CW-1:0] sx, sy, ex, ey;
  logic [CW-1:0] span_c, span_r;
  logic [1:0]    dir_c, dir_r;

  // The held word leaves whenever the queue has room.
  assign cmd_stall = held_valid && q_full;
  assign q_push    = held_valid && !q_full;
  assign q_data    = held;

  always_comb begin
    sx = CW'(cmd.start_x);
    sy = CW'(cmd.start_y);
    ex = CW'(cmd.end_x);
    ey = CW'(cmd.end_y);

    if (ex > sx) begin
      span_c = ex - sx;
      dir_c  = DIR_PLUS;
    end else if (ex < sx) begin
      span_c = sx - ex;
      dir_c  = DIR_MINUS;
    end else begin
      span_c = '0;
      dir_c  = DIR_NONE;
    end

    if (ey > sy) begin
      span_r = ey - sy;
      dir_r  = DIR_PLUS;
    end else if (ey < sy) begin
      span_r = sy - ey;
      dir_r  = DIR_MINUS;
    end else begin
      span_r = '0;
      dir_r  = DIR_NONE;
    end

    held_next.load     = (cmd.mode == MODE_LOAD);
    held_next.col      = sx;
    held_next.row      = sy;
    held_next.span_col = span_c;
    held_next.span_row = span_r;
    held_next.major    = (span_c > span_r) ? span_c : span_r;
    held_next.dir_col  = dir_c;
    held_next.dir_row  = dir_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!cmd_stall) begin
      held_valid <= cmd_valid;
    end
    if (cmd_valid && !cmd_stall) begin
      held <= held_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/lpg_back.sv =====
// Back of the line pixel generator: the error-accumulator stepper and the
// registered pixel output. Depends on lpg_pkg.
`default_nettype none

module lpg_back #(
  parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    q_nonempty,
  input  wire logic [lpg_pkg::cmd_bits(COORD_BITS)-1:0] q_data,
  output logic                                         q_pop,
  output logic                                         pix_valid,
  input  wire logic                                    pix_stall,
  output lpg_pkg::out_word_t                           pix
);

  import lpg_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int AW = COORD_BITS + 1;

  typedef struct packed {
    logic          load;
    logic [CW-1:0] col;
    logic [CW-1:0] row;
    logic [CW-1:0] span_col;
    logic [CW-1:0] span_row;
    logic [CW-1:0] major;
    logic [1:0]    dir_col;
    logic [1:0]    dir_row;
  } cmd_t;

  cmd_t          head;
  logic          room;
  logic          busy;
  logic [CW-1:0] cur_col, cur_row;
  logic [AW-1:0] acc_col, acc_row;
  logic [CW-1:0] span_col, span_row;
  logic [1:0]    dir_col, dir_row;
  logic [CW-1:0] major_span;
  logic [AW-1:0] steps_done;
  logic [AW-1:0] sum_col, sum_row;
  logic [AW-1:0] major_ext;
  logic          step_col, step_row;
  logic          is_last;
  logic          emit;

  function automatic logic [CW-1:0] move(input logic [CW-1:0] pos, input logic [1:0] dir);
    logic [CW-1:0] r;
    unique case (dir)
      DIR_PLUS:  r = pos + CW'(1);
      DIR_MINUS: r = pos - CW'(1);
      default:   r = pos;
    endcase
    return r;
  endfunction

  assign head  = q_data;
  assign room  = !pix_valid || !pix_stall;
  assign q_pop = q_nonempty && room;
  assign emit  = q_pop && !head.load && busy;

  always_comb begin
    major_ext = AW'(major_span);
    sum_col   = acc_col + AW'(span_col);
    sum_row   = acc_row + AW'(span_row);
    step_col  = sum_col > major_ext;
    step_row  = sum_row > major_ext;
    is_last   = (steps_done == major_ext + AW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pix_valid <= 1'b0;
    end else begin
      if (q_pop && head.load) begin
        busy <= 1'b1;
      end else if (emit && is_last) begin
        busy <= 1'b0;
      end
      if (room) begin
        pix_valid <= emit;
      end
    end

    if (q_pop && head.load) begin
      cur_col    <= head.col;
      cur_row    <= head.row;
      span_col   <= head.span_col;
      span_row   <= head.span_row;
      dir_col    <= head.dir_col;
      dir_row    <= head.dir_row;
      major_span <= head.major;
      acc_col    <= '0;
      acc_row    <= '0;
      steps_done <= '0;
    end else if (emit) begin
      acc_col    <= step_col ? sum_col - major_ext : sum_col;
      acc_row    <= step_row ? sum_row - major_ext : sum_row;
      cur_col    <= step_col ? move(cur_col, dir_col) : cur_col;
      cur_row    <= step_row ? move(cur_row, dir_row) : cur_row;
      steps_done <= steps_done + AW'(1);
    end

    if (emit) begin
      pix.pixel_x <= FIELD_BITS'(cur_col);
      pix.pixel_y <= FIELD_BITS'(cur_row);
      pix.last    <= is_last;
    end
  end

endmodule

`default_nettype wire

// ===== src/line_pixel_generator_unit.sv =====
// Top level of the line pixel generator: front, command queue and back.
// Depends on lpg_pkg, lpg_front, lpg_queue and lpg_back.
//
//   channel | signals                 | word          | direction
//   --------+-------------------------+---------------+----------
//   cmd     | cmd_valid, cmd_stall    | in_word_t     | in
//   pix     | pix_valid, pix_stall    | out_word_t    | out
//
// The block takes one word per clock while cmd_stall is low. A word is held
// in the front register, then written into the queue; the pixel of an advance
// word is registered in the output register once it leaves the queue. The
// stepper in the back updates both accumulators and the current pixel together,
// which sets the sustained rate of one pixel per clock while pix_stall is low.
// Reset is synchronous and active high; it leaves the block idle with an
// empty queue. A stall on the pixel side holds the output register, then
// fills the queue, and only then stalls the command side.
`default_nettype none

module line_pixel_generator_unit #(
  parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  output logic                    cmd_stall,
  input  wire lpg_pkg::in_word_t  cmd,
  output logic                    pix_valid,
  input  wire logic               pix_stall,
  output lpg_pkg::out_word_t      pix
);

  import lpg_pkg::*;

  localparam int QW = cmd_bits(COORD_BITS);

  logic          q_push;
  logic          q_full;
  logic          q_nonempty;
  logic          q_pop;
  logic [QW-1:0] q_in;
  logic [QW-1:0] q_out;

  // The front classifies each word and precomputes the line setup of a load.
  lpg_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .q_push    (q_push),
    .q_full    (q_full),
    .q_data    (q_in)
  );

  // The queue lets the front keep taking words while the output is stalled.
  lpg_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .nonempty  (q_nonempty),
    .pop       (q_pop),
    .pop_data  (q_out)
  );

  // The back steps the line and owns the registered pixel output.
  lpg_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_data     (q_out),
    .q_pop      (q_pop),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .pix        (pix)
  );

  // The command side is only held off when the queue has no room.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> q_full)
    else $error("command side stalled while the queue had room");

  // A held pixel must keep the back from consuming queued commands.
  a_no_pop_while_held: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && pix_stall) |-> !q_pop)
    else $error("queue popped while the output word was stalled");

  // A freshly presented pixel always comes from a command popped in the previous cycle.
  a_pixel_from_pop: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && !($past(pix_valid) && $past(pix_stall))) |-> $past(q_pop))
    else $error("pixel appeared without a popped command");

endmodule

`default_nettype wire

// ===== tb/sv/tb_line_pixel_generator_unit.sv =====
// Self-checking testbench for line_pixel_generator_unit: a line scoreboard
// predicts every pixel from the accepted command words. Depends on lpg_pkg.
// Directed corner lines come first, then random lines with random idling.
`default_nettype none

module tb_line_pixel_generator_unit;
  import lpg_pkg::*;

  // The instance keeps its default COORD_BITS, which equals the port field
  // width, so the predictor works at FIELD_BITS throughout.
  localparam int CW = FIELD_BITS;
  localparam int CMAX = (1 << CW) - 1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_WORDS = 950;

  // Scoreboard: a copy of the stepper state plus the queue of pixels that the
  // block still owes. Every accepted command word goes through note_command,
  // every accepted pixel word through check_pixel.
  class line_scoreboard;
    logic [CW-1:0] cur_col, cur_row;
    logic [11:0]   acc_col, acc_row;
    logic [CW-1:0] span_col, span_row, major_span;
    logic [1:0]    dir_col, dir_row;
    logic [11:0]   steps_done;
    bit            busy;
    out_word_t     owed_pixels[$];
    int            errors, pixels_checked, useful_words, lines_loaded, words_seen;

    function new();
      cur_col = '0; cur_row = '0; acc_col = '0; acc_row = '0;
      span_col = '0; span_row = '0; major_span = '0;
      dir_col = DIR_NONE; dir_row = DIR_NONE;
      steps_done = '0;
      busy = 1'b0;
      errors = 0; pixels_checked = 0; useful_words = 0; lines_loaded = 0;
      words_seen = 0;
    endfunction

    function void setup_axis(input logic [CW-1:0] from, input logic [CW-1:0] to,
                             output logic [CW-1:0] span, output logic [1:0] dir);
      if (to > from) begin
        span = to - from;
        dir = DIR_PLUS;
      end else if (to < from) begin
        span = from - to;
        dir = DIR_MINUS;
      end else begin
        span = '0;
        dir = DIR_NONE;
      end
    endfunction

    // The coordinate wraps naturally at its width.
    function logic [CW-1:0] step_axis(input logic [CW-1:0] pos, input logic [1:0] dir);
      if (dir == DIR_PLUS) return pos + 1'b1;
      if (dir == DIR_MINUS) return pos - 1'b1;
      return pos;
    endfunction

    function void note_command(input in_word_t w);
      out_word_t px;
      bit        final_px;
      words_seen++;
      if (w.mode == MODE_LOAD) begin
        setup_axis(w.start_x, w.end_x, span_col, dir_col);
        setup_axis(w.start_y, w.end_y, span_row, dir_row);
        major_span = (span_col > span_row) ? span_col : span_row;
        cur_col = w.start_x;
        cur_row = w.start_y;
        acc_col = '0;
        acc_row = '0;
        steps_done = '0;
        busy = 1'b1;
        useful_words++;
        lines_loaded++;
        return;
      end
      // An advance word while idle is simply dropped.
      if (!busy) return;
      useful_words++;
      final_px = (steps_done == {1'b0, major_span} + 12'd1);
      px.pixel_x = cur_col;
      px.pixel_y = cur_row;
      px.last = final_px;
      owed_pixels.push_back(px);
      acc_col = acc_col + {1'b0, span_col};
      acc_row = acc_row + {1'b0, span_row};
      if (acc_col > {1'b0, major_span}) begin
        acc_col = acc_col - {1'b0, major_span};
        cur_col = step_axis(cur_col, dir_col);
      end
      if (acc_row > {1'b0, major_span}) begin
        acc_row = acc_row - {1'b0, major_span};
        cur_row = step_axis(cur_row, dir_row);
      end
      steps_done = steps_done + 12'd1;
      if (final_px) busy = 1'b0;
    endfunction

    function void check_pixel(input out_word_t got);
      out_word_t want;
      if (owed_pixels.size() == 0) begin
        $display("%0t: pixel word with nothing owed: x=%0d y=%0d last=%0b",
                 $time, got.pixel_x, got.pixel_y, got.last);
        errors++;
        return;
      end
      want = owed_pixels.pop_front();
      pixels_checked++;
      if (got.pixel_x !== want.pixel_x) begin
        $display("%0t: pixel_x expected %0d actual %0d", $time, want.pixel_x, got.pixel_x);
        errors++;
      end
      if (got.pixel_y !== want.pixel_y) begin
        $display("%0t: pixel_y expected %0d actual %0d", $time, want.pixel_y, got.pixel_y);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return owed_pixels.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  in_word_t  cmd = '0;
  logic      pix_valid;
  logic      pix_stall = 1'b0;
  out_word_t pix;

  // While steady is set, neither side idles or stalls on its own.
  bit steady = 1'b0;
  int cycle_count = 0;
  int hold_left = 0;
  int holds_taken = 0;
  int stall_left = 0;

  line_scoreboard line_sb = new();

  line_pixel_generator_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix)
  );

  always #1 clk = ~clk;

  // Gap length in cycles: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Endpoint coordinate with extra weight on both edges of the range.
  function automatic int pick_coord();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 0;
    if (r == 1) return CMAX;
    return $urandom_range(0, CMAX);
  endfunction

  // Second endpoint within reach of the first, reflected to stay in range.
  function automatic int pick_partner(input int s, input int reach);
    int delta, e;
    delta = $urandom_range(0, 2 * reach) - reach;
    e = s + delta;
    if (e < 0 || e > CMAX) e = s - delta;
    return e;
  endfunction

  // Offers one word after an optional gap and returns once it is taken.
  // The word is noted at the edge that accepts it.
  task automatic send_word(input in_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= w;
    do @(posedge clk); while (cmd_stall);
    line_sb.note_command(w);
  endtask

  task automatic load_line(input int sx, input int sy, input int ex, input int ey);
    in_word_t w;
    w.mode = MODE_LOAD;
    w.start_x = sx[CW-1:0];
    w.start_y = sy[CW-1:0];
    w.end_x = ex[CW-1:0];
    w.end_y = ey[CW-1:0];
    send_word(w);
  endtask

  // Advance words carry random junk in the endpoint fields, which the block
  // must ignore.
  task automatic advance_pixels(input int count);
    in_word_t w;
    repeat (count) begin
      w = in_word_t'({$urandom, $urandom});
      w.mode = MODE_ADVANCE;
      send_word(w);
    end
  endtask

  // Pixel side: takes a word at every edge where valid is high and stall low,
  // then decides the stall for the next cycle. Twice during the run it holds
  // off for a long stretch so that the block fills up and stalls commands.
  always @(posedge clk) begin
    if (!rst) begin
      if (pix_valid && !pix_stall) line_sb.check_pixel(pix);
      if (hold_left == 0 && holds_taken < 2 &&
          line_sb.pixels_checked >= (holds_taken == 0 ? 120 : 450)) begin
        hold_left = 300;
        holds_taken++;
      end
      if (hold_left > 0) begin
        hold_left--;
        pix_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        pix_stall <= 1'b1;
      end else begin
        pix_stall <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  // Alternates stretches of random idling with stretches of none.
  initial begin
    forever begin
      repeat ($urandom_range(150, 400)) @(posedge clk);
      steady <= 1'b1;
      repeat ($urandom_range(40, 120)) @(posedge clk);
      steady <= 1'b0;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d pixels owed", cycle_count,
               line_sb.pending());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int sx, sy, ex, ey, reach, line_span, count;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Advance words right after reset find the block idle.
    advance_pixels(2);
    // A single point yields its pixel twice; the third advance finds it idle.
    load_line(5, 9, 5, 9);
    advance_pixels(3);
    // Full-range diagonal, cut short by a new load while still busy.
    load_line(0, 0, CMAX, CMAX);
    advance_pixels(3);
    load_line(CMAX, 0, 0, CMAX);
    advance_pixels(2);
    // Both axes stepping down from the top corner, run to completion.
    load_line(CMAX, CMAX, CMAX - 3, CMAX - 1);
    advance_pixels(5);
    // Purely horizontal line on the bottom edge; the row never moves.
    load_line(0, CMAX, 2, CMAX);
    advance_pixels(4);

    // Random part: mostly complete short lines, some medium ones, a few
    // full-range lines that are always abandoned early, and loose advances.
    while (line_sb.words_seen < RANDOM_WORDS) begin
      if ($urandom_range(0, 99) < 8) begin
        advance_pixels($urandom_range(1, 3));
      end else begin
        sx = pick_coord();
        sy = pick_coord();
        reach = ($urandom_range(0, 99) < 85) ? 12 : 60;
        if ($urandom_range(0, 19) == 0) begin
          ex = pick_coord();
          ey = pick_coord();
        end else begin
          ex = pick_partner(sx, reach);
          ey = pick_partner(sy, $urandom_range(0, reach));
        end
        line_span = (ex > sx) ? ex - sx : sx - ex;
        if (((ey > sy) ? ey - sy : sy - ey) > line_span)
          line_span = (ey > sy) ? ey - sy : sy - ey;
        if (line_span > 80 || $urandom_range(0, 4) == 0)
          count = $urandom_range(0, (line_span + 1 < 30) ? line_span + 1 : 30);
        else
          count = line_span + 2 + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
        load_line(sx, sy, ex, ey);
        advance_pixels(count);
      end
    end
    cmd_valid <= 1'b0;

    // Drain: wait for every owed pixel, then keep waiting for strays.
    while (line_sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (line_sb.pending() != 0) begin
      $display("%0d pixels still owed at the end", line_sb.pending());
      line_sb.errors++;
    end

    $display("Covered %0d lines in %0d command words (%0d working), %0d pixels checked,",
             line_sb.lines_loaded, line_sb.words_seen, line_sb.useful_words,
             line_sb.pixels_checked);
    $display("with %0d long pixel-side hold-offs and random gaps on both sides.",
             holds_taken);
    if (line_sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
